// ----- rtl/core/rcbd_pkg.sv -----
// ----------------------------------------------------------------------------
// rcbd_pkg
// Shared types, codes and helper functions of the reference-copy base decoder.
// ----------------------------------------------------------------------------
package rcbd_pkg;

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_T = 8'h54;

    localparam int START_W    = 24;
    localparam int RUN_W      = 7;
    localparam int LIT_W      = 64;
    localparam int COUNT_W    = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [2:0] {
        KIND_LOAD    = 3'd0,
        KIND_MATCH   = 3'd1,
        KIND_LITERAL = 3'd2,
        KIND_RESTART = 3'd3,
        KIND_CLEAR   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_RANGE = 2'd1,
        ERR_RUN   = 2'd2,
        ERR_FULL  = 2'd3
    } err_t;

    // Operations handed from the front part to the back part.
    typedef enum logic [2:0] {
        OP_LOAD    = 3'd0,
        OP_CLEAR   = 3'd1,
        OP_RESTART = 3'd2,
        OP_ERROR   = 3'd3,
        OP_MATCH   = 3'd4,
        OP_LITERAL = 3'd5
    } op_t;

    typedef enum logic {
        SEQ_IDLE = 1'b0,
        SEQ_RUN  = 1'b1
    } seq_state_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         char_in;
        logic [START_W-1:0] ref_delta;
        logic [RUN_W-1:0]   run_length;
        logic [LIT_W-1:0]   literal_bases;
    } req_t;

    typedef struct packed {
        logic [7:0]         base_char;
        logic [COUNT_W-1:0] target_index;
        logic               last;
        logic [1:0]         error;
    } rsp_t;

    // The code field holds the base code of a load or the error code of an error.
    typedef struct packed {
        op_t                op;
        logic [1:0]         code;
        logic [START_W-1:0] start;
        logic [RUN_W-1:0]   len;
        logic [LIT_W-1:0]   lits;
    } cmd_t;

    function automatic logic [7:0] code_to_char(input logic [1:0] code);
        logic [7:0] ch;
        begin
            unique case (code)
                2'd0:    ch = CHAR_A;
                2'd1:    ch = CHAR_C;
                2'd2:    ch = CHAR_G;
                default: ch = CHAR_T;
            endcase
            return ch;
        end
    endfunction

    // Returns the valid flag in bit 2 and the base code in bits 1..0.
    function automatic logic [2:0] char_to_code(input logic [7:0] ch);
        logic [2:0] res;
        begin
            unique case (ch)
                CHAR_A:  res = 3'b100;
                CHAR_C:  res = 3'b101;
                CHAR_G:  res = 3'b110;
                CHAR_T:  res = 3'b111;
                default: res = 3'b000;
            endcase
            return res;
        end
    endfunction

endpackage

// ----- rtl/core/rcbd_front.sv -----
// ----------------------------------------------------------------------------
// rcbd_front
// Accepts items, checks them against the reference fill and the match chain,
// and turns each into at most one command for the back part.
// ----------------------------------------------------------------------------
module rcbd_front #(
    parameter int REF_DEPTH       = 16777216,
    parameter int MAX_MATCH_RUN   = 64,
    parameter int MAX_LITERAL_RUN = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  rcbd_pkg::req_t  req,
    output logic            push,
    output rcbd_pkg::cmd_t  push_data,
    input  logic            full
);
    import rcbd_pkg::*;

    localparam int FW = $clog2(REF_DEPTH + 1);
    localparam int CW = (FW > START_W + 1) ? FW : START_W + 1;
    localparam logic [FW-1:0]    DEPTH_C     = FW'(REF_DEPTH);
    localparam logic [RUN_W-1:0] MAX_MATCH_C = RUN_W'(MAX_MATCH_RUN);
    localparam logic [RUN_W-1:0] MAX_LIT_C   = RUN_W'(MAX_LITERAL_RUN);

    logic [FW-1:0]      fill_reg, fill_next;
    logic [START_W-1:0] prev_start_reg, prev_start_next;
    logic [START_W-1:0] match_start;
    logic [CW-1:0]      match_end;
    logic [2:0]         char_code;
    logic               accept;
    logic               push_c;
    cmd_t               cmd_c;

    assign req_ready   = !full;
    assign accept      = req_valid && req_ready;
    assign match_start = prev_start_reg + req.ref_delta;
    assign match_end   = CW'(match_start) + CW'(req.run_length);
    assign char_code   = char_to_code(req.char_in);

    always_comb
    begin
        cmd_c           = '0;
        cmd_c.op        = OP_LOAD;
        cmd_c.start     = match_start;
        cmd_c.len       = req.run_length;
        cmd_c.lits      = req.literal_bases;
        push_c          = 1'b0;
        fill_next       = fill_reg;
        prev_start_next = prev_start_reg;
        unique case (kind_t'(req.kind))
            KIND_LOAD:
            begin
                if (char_code[2])
                begin
                    push_c = 1'b1;
                    if (fill_reg >= DEPTH_C)
                    begin
                        cmd_c.op   = OP_ERROR;
                        cmd_c.code = ERR_FULL;
                    end
                    else
                    begin
                        cmd_c.op   = OP_LOAD;
                        cmd_c.code = char_code[1:0];
                        fill_next  = fill_reg + 1'b1;
                    end
                end
            end
            KIND_MATCH:
            begin
                if (req.run_length > MAX_MATCH_C)
                begin
                    push_c     = 1'b1;
                    cmd_c.op   = OP_ERROR;
                    cmd_c.code = ERR_RUN;
                end
                else if (match_end > CW'(fill_reg))
                begin
                    push_c     = 1'b1;
                    cmd_c.op   = OP_ERROR;
                    cmd_c.code = ERR_RANGE;
                end
                else
                begin
                    // An empty match still moves the chain but makes no bases.
                    prev_start_next = match_start;
                    push_c          = (req.run_length != '0);
                    cmd_c.op        = OP_MATCH;
                end
            end
            KIND_LITERAL:
            begin
                if (req.run_length > MAX_LIT_C)
                begin
                    push_c     = 1'b1;
                    cmd_c.op   = OP_ERROR;
                    cmd_c.code = ERR_RUN;
                end
                else
                begin
                    push_c   = (req.run_length != '0);
                    cmd_c.op = OP_LITERAL;
                end
            end
            KIND_RESTART:
            begin
                prev_start_next = '0;
                push_c          = 1'b1;
                cmd_c.op        = OP_RESTART;
            end
            KIND_CLEAR:
            begin
                fill_next = '0;
                push_c    = 1'b1;
                cmd_c.op  = OP_CLEAR;
            end
            default:
            begin
                push_c = 1'b0;
            end
        endcase
    end

    assign push      = accept && push_c;
    assign push_data = cmd_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            prev_start_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg       <= fill_next;
            prev_start_reg <= prev_start_next;
        end
    end

endmodule

// ----- rtl/core/rcbd_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// rcbd_cmd_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module rcbd_cmd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rcbd_pkg::cmd_t  push_data,
    input  logic            pop,
    output rcbd_pkg::cmd_t  pop_data,
    output logic            full,
    output logic            empty
);
    import rcbd_pkg::*;

    cmd_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;

    assign full     = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= FIFO_AW'(32'(wr_ptr_reg + 1'b1) % FIFO_DEPTH);
            end
            if (pop)
            begin
                rd_ptr_reg <= FIFO_AW'(32'(rd_ptr_reg + 1'b1) % FIFO_DEPTH);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/rcbd_back.sv -----
// ----------------------------------------------------------------------------
// rcbd_back
// Executes commands: owns the reference memory and the emitted-base counter,
// and steps through match and literal runs one base per cycle unless stalled.
// ----------------------------------------------------------------------------
module rcbd_back #(
    parameter int REF_DEPTH = 16777216
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            empty,
    output logic            pop,
    input  rcbd_pkg::cmd_t  head,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output rcbd_pkg::rsp_t  rsp
);
    import rcbd_pkg::*;

    localparam int AW = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
    localparam int FW = $clog2(REF_DEPTH + 1);

    logic [1:0] ref_mem [REF_DEPTH];
    logic [1:0] rd_data_reg;

    seq_state_t         seq_state_reg, seq_state_next;
    logic               run_match_reg;
    logic [AW-1:0]      rd_addr_reg;
    logic [LIT_W-1:0]   lits_reg;
    logic [RUN_W-1:0]   remain_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [FW-1:0]      wr_ptr_reg;

    logic               s1_valid_reg;
    logic               s1_is_match_reg;
    logic [1:0]         s1_code_reg;
    logic [1:0]         s1_err_reg;
    logic [COUNT_W-1:0] s1_index_reg;
    logic               s1_last_reg;

    logic rsp_valid_reg;
    rsp_t rsp_reg;

    logic out_free, issue_ok;
    logic mem_we, rd_en, start_run, do_restart, do_clear, err_issue, base_issue;
    logic [1:0] out_code;

    assign out_free = !rsp_valid_reg || rsp_ready;
    assign issue_ok = !s1_valid_reg || out_free;

    // Sequencer next state.
    always_comb
    begin
        seq_state_next = seq_state_reg;
        unique case (seq_state_reg)
            SEQ_IDLE:
            begin
                if (!empty && (head.op == OP_MATCH || head.op == OP_LITERAL))
                begin
                    seq_state_next = SEQ_RUN;
                end
            end
            SEQ_RUN:
            begin
                if (issue_ok && remain_reg == RUN_W'(1))
                begin
                    seq_state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                seq_state_next = SEQ_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        pop        = 1'b0;
        mem_we     = 1'b0;
        rd_en      = 1'b0;
        start_run  = 1'b0;
        do_restart = 1'b0;
        do_clear   = 1'b0;
        err_issue  = 1'b0;
        base_issue = 1'b0;
        unique case (seq_state_reg)
            SEQ_IDLE:
            begin
                if (!empty)
                begin
                    unique case (head.op)
                        OP_LOAD:
                        begin
                            pop    = 1'b1;
                            mem_we = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            pop      = 1'b1;
                            do_clear = 1'b1;
                        end
                        OP_RESTART:
                        begin
                            pop        = 1'b1;
                            do_restart = 1'b1;
                        end
                        OP_ERROR:
                        begin
                            pop       = issue_ok;
                            err_issue = issue_ok;
                        end
                        OP_MATCH, OP_LITERAL:
                        begin
                            pop       = 1'b1;
                            start_run = 1'b1;
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            SEQ_RUN:
            begin
                base_issue = issue_ok;
                rd_en      = issue_ok && run_match_reg;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ref_mem[wr_ptr_reg[AW-1:0]] <= head.code;
        end
        if (rd_en)
        begin
            rd_data_reg <= ref_mem[rd_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_state_reg <= SEQ_IDLE;
            run_match_reg <= 1'b0;
            remain_reg    <= '0;
            count_reg     <= '0;
            wr_ptr_reg    <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            seq_state_reg <= seq_state_next;
            if (mem_we)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_clear)
            begin
                wr_ptr_reg <= '0;
            end
            if (do_restart)
            begin
                count_reg <= '0;
            end
            if (start_run)
            begin
                run_match_reg <= (head.op == OP_MATCH);
                remain_reg    <= head.len;
            end
            if (base_issue)
            begin
                remain_reg <= remain_reg - 1'b1;
                if (count_reg != '1)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (base_issue || err_issue)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Run datapath and the stage that waits for the memory read.
    always_ff @(posedge clk)
    begin
        if (start_run)
        begin
            rd_addr_reg <= AW'(head.start);
            lits_reg    <= head.lits;
        end
        else if (base_issue)
        begin
            rd_addr_reg <= rd_addr_reg + 1'b1;
            lits_reg    <= lits_reg >> 2;
        end
        if (base_issue)
        begin
            s1_is_match_reg <= run_match_reg;
            s1_code_reg     <= lits_reg[1:0];
            s1_err_reg      <= ERR_NONE;
            s1_index_reg    <= count_reg;
            s1_last_reg     <= (remain_reg == RUN_W'(1));
        end
        else if (err_issue)
        begin
            s1_is_match_reg <= 1'b0;
            s1_code_reg     <= '0;
            s1_err_reg      <= head.code;
            s1_index_reg    <= count_reg;
            s1_last_reg     <= 1'b1;
        end
    end

    assign out_code = s1_is_match_reg ? rd_data_reg : s1_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (s1_valid_reg && out_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && out_free)
        begin
            rsp_reg.base_char    <= (s1_err_reg != ERR_NONE) ? 8'h00
                                                             : code_to_char(out_code);
            rsp_reg.target_index <= s1_index_reg;
            rsp_reg.last         <= s1_last_reg;
            rsp_reg.error        <= s1_err_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- rtl/core/reference_copy_base_decoder_unit.sv -----
// Path: an accepted item enters the command queue; the sequencer starts a match or literal run,
// and each base passes the memory-read stage and the output register; an error skips the run.
// Throughput: the back part emits one base per cycle, while the output is not stalled, from the
// reference memory's single read port; loads, restarts and clears produce no output.
// The front accepts one item per cycle while the four-entry command queue has room.
// Reset clears counters, the match chain and the queue; the reference memory is not cleared.
// ----------------------------------------------------------------------------
// reference_copy_base_decoder_unit
// Rebuilds an A/C/G/T base stream from reference copies and literal runs.
// ----------------------------------------------------------------------------
module reference_copy_base_decoder_unit #(
    parameter int REF_DEPTH       = 16777216,
    parameter int MAX_MATCH_RUN   = 64,
    parameter int MAX_LITERAL_RUN = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  rcbd_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output rcbd_pkg::rsp_t  rsp
);
    import rcbd_pkg::*;

    logic push, pop, full, empty;
    cmd_t push_data, head;

    rcbd_front #(
        .REF_DEPTH       (REF_DEPTH),
        .MAX_MATCH_RUN   (MAX_MATCH_RUN),
        .MAX_LITERAL_RUN (MAX_LITERAL_RUN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    rcbd_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (head),
        .full      (full),
        .empty     (empty)
    );

    rcbd_back #(
        .REF_DEPTH (REF_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .pop       (pop),
        .head      (head),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ----- dv/reference_copy_base_decoder_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reference_copy_base_decoder_unit_tb
// Self-checking bench for the reference-copy base decoder. Every accepted item
// is decoded by a bench model that keeps its own copy of the reference, the
// match chain and the output count. The expected bases are queued, and each
// emitted item is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
module reference_copy_base_decoder_unit_tb;
    import rcbd_pkg::*;

    localparam int unsigned DEPTH        = 16777216;
    // The run loads far fewer bases than this, so the bench copy stays small.
    localparam int unsigned BENCH_STORE  = 4096;
    localparam int unsigned MATCH_MAX    = 64;
    localparam int unsigned LITERAL_MAX  = 32;
    localparam int unsigned RANDOM_ITEMS = 420;
    localparam int unsigned QUIET_ITEMS  = 60;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam logic [31:0] BASE_ASCII   = {CHAR_T, CHAR_G, CHAR_C, CHAR_A};

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // Bench copy of the decoder state.
    logic [1:0]         ref_codes [BENCH_STORE];
    int unsigned        ref_fill    = 0;
    logic [START_W-1:0] match_start = '0;
    logic [COUNT_W-1:0] base_count  = '0;
    rsp_t               pending_bases [$];

    int unsigned mismatch_count = 0;
    int unsigned work_items     = 0;
    int unsigned cycle_count    = 0;
    int unsigned rsp_gap        = 0;
    bit          req_gaps       = 1'b1;
    bit          rsp_stalls     = 1'b1;
    bit          hold_rsp       = 1'b0;

    reference_copy_base_decoder_unit #(
        .REF_DEPTH      (DEPTH),
        .MAX_MATCH_RUN  (MATCH_MAX),
        .MAX_LITERAL_RUN(LITERAL_MAX)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $time, msg);
    endfunction

    function automatic void push_result(input logic [7:0] ch, input logic fin,
                                        input err_t err);
        rsp_t r;
        r.base_char    = ch;
        r.target_index = base_count;
        r.last         = fin;
        r.error        = err;
        pending_bases = {pending_bases, r};
        if (err == ERR_NONE && base_count != '1)
            base_count++;
    endfunction

    // Updates the bench state for one accepted item and queues its bases.
    function automatic void decode_item(input req_t item);
        logic [START_W-1:0] start;
        logic [1:0]         code;
        bit                 is_base;
        int unsigned        i;
        case (item.kind)
            KIND_LOAD:
            begin
                is_base = 1'b0;
                code    = 2'd0;
                for (i = 0; i < 4; i++)
                    if (item.char_in == BASE_ASCII[8*i +: 8])
                    begin
                        is_base = 1'b1;
                        code    = 2'(i);
                    end
                if (is_base && ref_fill >= DEPTH)
                    push_result(8'h00, 1'b1, ERR_FULL);
                else if (is_base)
                begin
                    ref_codes[ref_fill] = code;
                    ref_fill++;
                end
            end
            KIND_MATCH:
            begin
                start = match_start + item.ref_delta;
                if (item.run_length > MATCH_MAX)
                    push_result(8'h00, 1'b1, ERR_RUN);
                else if (32'(start) + 32'(item.run_length) > ref_fill)
                    push_result(8'h00, 1'b1, ERR_RANGE);
                else
                begin
                    match_start = start;
                    for (i = 0; i < item.run_length; i++)
                        push_result(BASE_ASCII[8*ref_codes[32'(start) + i] +: 8],
                                    i + 1 == item.run_length, ERR_NONE);
                end
            end
            KIND_LITERAL:
            begin
                if (item.run_length > LITERAL_MAX)
                    push_result(8'h00, 1'b1, ERR_RUN);
                else
                    for (i = 0; i < item.run_length; i++)
                        push_result(BASE_ASCII[8*item.literal_bases[2*i +: 2] +: 8],
                                    i + 1 == item.run_length, ERR_NONE);
            end
            KIND_RESTART:
            begin
                match_start = '0;
                base_count  = '0;
            end
            KIND_CLEAR:
                ref_fill = 0;
            default:
                ;
        endcase
    endfunction

    // Fields that the kind does not use carry random values.
    function automatic req_t junk_item(input logic [2:0] kind);
        req_t item;
        item.kind          = kind;
        item.char_in       = 8'($urandom);
        item.ref_delta     = 24'($urandom);
        item.run_length    = 7'($urandom);
        item.literal_bases = {$urandom, $urandom};
        return item;
    endfunction

    function automatic req_t load_item(input logic [7:0] ch);
        req_t item;
        item         = junk_item(KIND_LOAD);
        item.char_in = ch;
        return item;
    endfunction

    function automatic req_t match_item(input logic [23:0] delta, input logic [6:0] len);
        req_t item;
        item            = junk_item(KIND_MATCH);
        item.ref_delta  = delta;
        item.run_length = len;
        return item;
    endfunction

    function automatic req_t literal_item(input logic [6:0] len, input logic [63:0] bits);
        req_t item;
        item               = junk_item(KIND_LITERAL);
        item.run_length    = len;
        item.literal_bases = bits;
        return item;
    endfunction

    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom);
        return BASE_ASCII[8*$urandom_range(0, 3) +: 8];
    endfunction

    // Valid is only lowered for an idle gap before an item, so back-to-back items keep it high.
    task automatic send_item(input req_t item);
        int unsigned gap;
        gap = (req_gaps && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_ready !== 1'b1)
            @(posedge clk);
        decode_item(item);
        if (item.kind <= KIND_CLEAR)
            work_items++;
    endtask

    task automatic load_burst(input int unsigned count);
        int unsigned i;
        for (i = 0; i < count; i++)
            send_item(load_item(pick_char()));
    endtask

    always @(negedge clk)
    begin
        if (hold_rsp)
            rsp_ready <= 1'b0;
        else if (rsp_gap != 0)
        begin
            rsp_gap   <= rsp_gap - 1;
            rsp_ready <= 1'b0;
        end
        else if (rsp_stalls && $urandom_range(0, 9) == 0)
        begin
            rsp_gap   <= $urandom_range(0, 11);
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_ready === 1'b1)
        begin
            if (pending_bases.size() == 0)
                note_failure($sformatf("unexpected item: char %h index %0d last %b error %0d",
                                       rsp.base_char, rsp.target_index, rsp.last, rsp.error));
            else
            begin
                want = pending_bases.pop_front();
                if (rsp.base_char !== want.base_char || rsp.target_index !== want.target_index
                    || rsp.last !== want.last || rsp.error !== want.error)
                    note_failure($sformatf({"mismatch: expected char %h index %0d last %b ",
                                            "error %0d, got char %h index %0d last %b error %0d"},
                                           want.base_char, want.target_index, want.last,
                                           want.error, rsp.base_char, rsp.target_index,
                                           rsp.last, rsp.error));
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Dropped bytes, chain wrap, empty runs, both run limits, unused kinds and
    // a match into an emptied reference.
    task automatic test_directed();
        int unsigned i;
        logic [63:0] seed_ref;
        seed_ref = "ACGTTGCA";
        send_item(load_item(8'h00));
        send_item(load_item(8'hFF));
        for (i = 0; i < 8; i++)
            send_item(load_item(seed_ref[8*(7-i) +: 8]));
        send_item(match_item(24'd0, 7'd4));
        send_item(match_item(24'd2, 7'd0));
        send_item(match_item(24'd1, 7'd5));
        send_item(match_item(24'd1, 7'd5));
        send_item(match_item(24'hFFFFFF, 7'd1));
        send_item(match_item(24'd0, 7'h7F));
        send_item(literal_item(7'(LITERAL_MAX), 64'hFFFF_FFFF_FFFF_FFFF));
        send_item(literal_item(7'(LITERAL_MAX + 1), {$urandom, $urandom}));
        send_item(literal_item(7'd0, {$urandom, $urandom}));
        send_item(literal_item(7'd4, 64'hE4));
        send_item(junk_item(KIND_RESTART));
        send_item(junk_item(3'd5));
        send_item(junk_item(3'd7));
        send_item(literal_item(7'd1, 64'd0));
        send_item(junk_item(KIND_CLEAR));
        send_item(match_item(24'd0, 7'd1));
    endtask

    // The receiver stalls long enough for the command queue to fill up.
    task automatic test_pressure();
        int unsigned n;
        fork
            begin
                hold_rsp = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
            end
        join_none
        for (n = 0; n < 12; n++)
            send_item(literal_item(7'(LITERAL_MAX), {$urandom, $urandom}));
    endtask

    // Mostly in-range matches and legal literals over a live reference, with
    // some malformed items mixed in.
    task automatic test_random();
        int unsigned first;
        int unsigned pick;
        int unsigned len;
        int unsigned pos;
        first = work_items;
        send_item(junk_item(KIND_CLEAR));
        load_burst($urandom_range(16, 64));
        while (work_items - first < RANDOM_ITEMS)
        begin
            if (work_items - first >= RANDOM_ITEMS - QUIET_ITEMS)
            begin
                req_gaps   = 1'b0;
                rsp_stalls = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
                load_burst($urandom_range(4, 40));
            else if (pick < 10)
            begin
                send_item(junk_item(KIND_CLEAR));
                load_burst($urandom_range(16, 64));
            end
            else if (pick < 13)
                send_item(junk_item(KIND_RESTART));
            else if (pick < 50)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MATCH_MAX)
                                                  : $urandom_range(1, 12);
                if (len > ref_fill)
                    len = ref_fill;
                pos = $urandom_range(0, ref_fill - len);
                send_item(match_item(24'(pos) - match_start, 7'(len)));
            end
            else if (pick < 74)
                send_item(literal_item(7'($urandom_range(0, LITERAL_MAX)),
                                       {$urandom, $urandom}));
            else if (pick < 84)
                send_item(match_item(24'($urandom), 7'($urandom_range(0, 127))));
            else if (pick < 92)
                send_item(literal_item(7'($urandom_range(0, 127)), {$urandom, $urandom}));
            else
                send_item(junk_item(3'($urandom_range(0, 7))));
        end
    endtask

    initial
    begin : main
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_pressure();
        test_random();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_bases.size() != 0)
            @(posedge clk);
        // Give a stray extra item time to show up.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
